### design/assert_macros.svh
// assertion helpers, clocked on clk with reset arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### design/cpa_pkg.sv
package cpa_pkg;

	localparam int NUM_PAGES  = 4096;
	localparam int OWNER_BITS = 8;
	localparam int PAGE_SHIFT = 12;
	localparam int PAGE_W     = $clog2(NUM_PAGES);
	localparam int SIZE_W     = 25;
	localparam int ADDR_W     = 32;
	localparam int OWNER_W    = 8;
	localparam int FIRST_W    = ADDR_W - PAGE_SHIFT;
	localparam int CNT_W      = SIZE_W - PAGE_SHIFT + 1;

	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_FREE  = 2'd1;
	localparam logic [1:0] MODE_RETAG = 2'd2;

	localparam logic STATUS_DONE     = 1'b0;
	localparam logic STATUS_NO_SPACE = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	typedef enum logic [1:0] {
		W_SET,
		W_CLR,
		W_TAG
	} wkind_t;

endpackage

### design/contiguous_page_allocator.sv
// contiguous_page_allocator: first-fit allocator over a bitmap of 4 KiB pages
//
// command channel: raise start with mode, size_bytes, address and owner_id;
// the item is taken on a clock edge where start is high and busy is low.
// one result per item: done is high for exactly one cycle with base_address
// and status; the receiver cannot hold it off and must take it then.
// allocate reads the used-flag memory one page per cycle from page 0 until a
// free run of the requested length is found, then writes one page per cycle
// to mark it; a failed search reads up to the last page and answers with
// NO_SPACE. free and change-owner write one page per cycle, stopping at the
// last page. oversize allocations, unused modes, and free or change-owner
// starting beyond the last page answer straight from idle, without touching
// the page memories. the page memories have a single read port and a single
// write port; one item is worked on at a time.
// after reset a clearing pass zeroes the flags and owners of all NUM_PAGES
// pages, one per cycle; busy stays high until it ends.
`include "assert_macros.svh"

module contiguous_page_allocator
	import cpa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          mode,
	input  logic [SIZE_W-1:0]   size_bytes,
	input  logic [ADDR_W-1:0]   address,
	input  logic [OWNER_W-1:0]  owner_id,
	output logic                done,
	output logic [ADDR_W-1:0]   base_address,
	output logic                status
);

	localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(NUM_PAGES - 1);
	localparam logic [PAGE_W:0]   END_ADDR  = (PAGE_W + 1)'(NUM_PAGES);

	state_t                state_q, state_d;
	wkind_t                wkind_q;
	logic                  done_q;
	logic [ADDR_W-1:0]     base_q;
	logic                  status_q;
	logic [PAGE_W:0]       ra_q;
	logic                  rv_q;
	logic [PAGE_W-1:0]     rpg_q;
	logic [CNT_W-1:0]      run_q;
	logic [PAGE_W-1:0]     wa_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W-1:0]      n_q;
	logic [OWNER_BITS-1:0] own_q;
	logic                  used_rd_q;

	logic                  used_mem [NUM_PAGES];
	logic [OWNER_BITS-1:0] own_mem  [NUM_PAGES];

	logic                  accept;
	logic [SIZE_W-1:0]     szm1;
	logic [CNT_W-1:0]      n_in;
	logic [FIRST_W-1:0]    first_in;
	logic                  too_big;
	logic                  first_out;
	logic [CNT_W-1:0]      run_inc;
	logic [PAGE_W:0]       start_pg;
	logic                  wr_en;
	logic                  scan_hit;
	logic                  scan_fail;
	logic                  wr_last;
	logic                  imm_done;

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign base_address = base_q;
	assign status       = status_q;

	assign accept    = start && (state_q == ST_IDLE);
	assign szm1      = size_bytes - SIZE_W'(1);
	assign n_in      = (size_bytes == '0) ? CNT_W'(1) :
		CNT_W'(szm1[SIZE_W-1:PAGE_SHIFT]) + CNT_W'(1);
	assign first_in  = address[ADDR_W-1:PAGE_SHIFT];
	assign too_big   = (32'(n_in) > 32'(NUM_PAGES));
	assign first_out = (32'(first_in) >= 32'(NUM_PAGES));
	assign run_inc   = run_q + CNT_W'(1);
	assign start_pg  = (PAGE_W + 1)'(rpg_q) + (PAGE_W + 1)'(1) - (PAGE_W + 1)'(n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		wr_en     = 1'b0;
		scan_hit  = 1'b0;
		scan_fail = 1'b0;
		wr_last   = 1'b0;
		imm_done  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				if (wa_q == LAST_PAGE) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (mode)
						MODE_ALLOC: begin
							if (!too_big) begin
								state_d = ST_SCAN;
							end else begin
								imm_done = 1'b1;
							end
						end
						MODE_FREE, MODE_RETAG: begin
							if (!first_out) begin
								state_d = ST_WRITE;
							end else begin
								imm_done = 1'b1;
							end
						end
						default: begin
							state_d  = ST_IDLE;
							imm_done = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (rv_q) begin
					if (!used_rd_q && (run_inc == n_q)) begin
						scan_hit = 1'b1;
						state_d  = ST_WRITE;
					end else if (rpg_q == LAST_PAGE) begin
						scan_fail = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
			ST_WRITE: begin
				wr_en = 1'b1;
				if ((rem_q == CNT_W'(1)) || (wa_q == LAST_PAGE)) begin
					wr_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			base_q   <= '0;
			status_q <= STATUS_DONE;
			ra_q     <= '0;
			rv_q     <= 1'b0;
			rpg_q    <= '0;
			run_q    <= '0;
			wa_q     <= '0;
			rem_q    <= '0;
			wkind_q  <= W_CLR;
		end else begin
			done_q <= imm_done || scan_fail || wr_last;
			if (accept) begin
				base_q <= '0;
				case (mode)
					MODE_ALLOC: begin
						ra_q     <= '0;
						rv_q     <= 1'b0;
						run_q    <= '0;
						wkind_q  <= W_SET;
						status_q <= too_big ? STATUS_NO_SPACE : STATUS_DONE;
					end
					MODE_FREE, MODE_RETAG: begin
						wkind_q  <= (mode == MODE_FREE) ? W_CLR : W_TAG;
						wa_q     <= PAGE_W'(first_in);
						rem_q    <= n_in;
						status_q <= STATUS_DONE;
					end
					default: status_q <= STATUS_DONE;
				endcase
			end
			if (state_q == ST_SCAN) begin
				if (ra_q != END_ADDR) begin
					ra_q  <= ra_q + (PAGE_W + 1)'(1);
					rv_q  <= 1'b1;
					rpg_q <= ra_q[PAGE_W-1:0];
				end else begin
					rv_q <= 1'b0;
				end
				if (rv_q) begin
					run_q <= used_rd_q ? '0 : run_inc;
				end
				if (scan_hit) begin
					wa_q   <= start_pg[PAGE_W-1:0];
					rem_q  <= n_q;
					base_q <= ADDR_W'(start_pg[PAGE_W-1:0]) << PAGE_SHIFT;
				end
				if (scan_fail) begin
					status_q <= STATUS_NO_SPACE;
					base_q   <= '0;
				end
			end
			if (wr_en) begin
				wa_q  <= wa_q + PAGE_W'(1);
				rem_q <= rem_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q   <= n_in;
			own_q <= OWNER_BITS'(owner_id);
		end
	end

	// page memories: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en && (wkind_q != W_TAG)) begin
			used_mem[wa_q] <= (wkind_q == W_SET);
		end
		if (wr_en) begin
			own_mem[wa_q] <= (wkind_q == W_CLR) ? '0 : own_q;
		end
		used_rd_q <= used_mem[ra_q[PAGE_W-1:0]];
	end

	`ASSERT_CLK(a_done_idle, done |-> !busy, "result strobe while still busy")
	`ASSERT_CLK(a_fail_zero, (done && status) |-> (base_address == '0),
		"failed allocation with nonzero base")
	`ASSERT_CLK(a_accept_moves, (start && !busy) |=> (busy || done),
		"accepted item neither started nor answered")
	`ASSERT_NEVER(a_no_idle_write, (state_q == ST_IDLE) && wr_en,
		"page memory written while idle")
	`ASSERT_NEVER(a_scan_write, (state_q == ST_SCAN) && wr_en,
		"page memory written during scan")

endmodule

### tb/tb_contiguous_page_allocator.sv
`timescale 1ns / 1ps

module tb_contiguous_page_allocator;
	import cpa_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int PAGE_BYTES = 1 << PAGE_SHIFT;
	localparam int MAX_SIZE = NUM_PAGES * PAGE_BYTES;
	localparam int RANDOM_ITEMS = 140;
	localparam int IDLE_LIMIT = 40000;

	typedef struct packed {
		logic [1:0]         mode;
		logic [SIZE_W-1:0]  size_bytes;
		logic [ADDR_W-1:0]  address;
		logic [OWNER_W-1:0] owner_id;
	} page_request_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base_address;
		logic              status;
	} alloc_result_t;

	typedef struct {
		int first_page;
		int pages;
	} page_run_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         mode = '0;
	logic [SIZE_W-1:0]  size_bytes = '0;
	logic [ADDR_W-1:0]  address = '0;
	logic [OWNER_W-1:0] owner_id = '0;
	logic               busy;
	logic               done;
	logic [ADDR_W-1:0]  base_address;
	logic               status;

	bit                 page_used_map [NUM_PAGES];
	bit [OWNER_W-1:0]   page_owner_map [NUM_PAGES];

	page_request_t      pending_reqs [$];
	alloc_result_t      awaited_results [$];
	page_run_t          live_runs [$];
	page_request_t      driven_req;

	int queued_count = 0;
	int accepted_count = 0;
	int error_count = 0;
	int burst_left = 3;
	int gap_left = 0;
	int idle_cycles = 0;

	contiguous_page_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.size_bytes   (size_bytes),
		.address      (address),
		.owner_id     (owner_id),
		.done         (done),
		.base_address (base_address),
		.status       (status)
	);

	always #6 clk = ~clk;

	function automatic int pages_for_size(logic [SIZE_W-1:0] nbytes);
		if (nbytes == 0)
			return 1;
		return (nbytes - 1) / PAGE_BYTES + 1;
	endfunction

	// updates the page maps and returns the answer the block should give
	function automatic alloc_result_t apply_page_request(page_request_t req);
		alloc_result_t res;
		int cnt;
		int run;
		int pg;
		int start_pg;
		int first_pg;
		res = '0;
		res.status = STATUS_DONE;
		cnt = pages_for_size(req.size_bytes);
		first_pg = int'(req.address >> PAGE_SHIFT);
		case (req.mode)
			MODE_ALLOC: begin
				res.status = STATUS_NO_SPACE;
				run = 0;
				if (cnt <= NUM_PAGES) begin
					for (pg = 0; pg < NUM_PAGES && run < cnt; pg++)
						run = page_used_map[pg] ? 0 : run + 1;
					if (run == cnt) begin
						start_pg = pg - cnt;
						for (int k = start_pg; k < pg; k++) begin
							page_used_map[k] = 1'b1;
							page_owner_map[k] = req.owner_id;
						end
						res.base_address = ADDR_W'(start_pg) << PAGE_SHIFT;
						res.status = STATUS_DONE;
						live_runs.push_back('{start_pg, cnt});
					end
				end
			end
			MODE_FREE: begin
				for (pg = first_pg; pg < first_pg + cnt && pg < NUM_PAGES; pg++) begin
					page_used_map[pg] = 1'b0;
					page_owner_map[pg] = '0;
				end
			end
			MODE_RETAG: begin
				for (pg = first_pg; pg < first_pg + cnt && pg < NUM_PAGES; pg++)
					page_owner_map[pg] = req.owner_id;
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		error_count++;
	endtask

	task automatic send_request(logic [1:0] m, int unsigned s, logic [ADDR_W-1:0] a,
			int unsigned o);
		while (pending_reqs.size() >= 2)
			@(posedge clk);
		pending_reqs.push_back('{m, SIZE_W'(s), a, OWNER_W'(o)});
		queued_count++;
	endtask

	task automatic wait_for_drain();
		while (accepted_count < queued_count || awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// driver: bursts of items separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			mode <= '0;
			size_bytes <= '0;
			address <= '0;
			owner_id <= '0;
		end else if (!(start && busy)) begin
			if (start) begin
				awaited_results.push_back(apply_page_request(driven_req));
				accepted_count++;
			end
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				driven_req = pending_reqs.pop_front();
				mode <= driven_req.mode;
				size_bytes <= driven_req.size_bytes;
				address <= driven_req.address;
				owner_id <= driven_req.owner_id;
				start <= 1'b1;
				burst_left--;
				if (burst_left == 0) begin
					burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
						: $urandom_range(1, 6);
					case ($urandom_range(0, 3))
						0: gap_left = 0;
						3: gap_left = $urandom_range(10, 40);
						default: gap_left = $urandom_range(1, 4);
					endcase
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin : result_check
		alloc_result_t exp_res;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				report_mismatch($sformatf("result with no item waiting: base %h status %0d",
					base_address, status));
			end else begin
				exp_res = awaited_results.pop_front();
				if (base_address !== exp_res.base_address)
					report_mismatch($sformatf("base_address %h, predicted %h",
						base_address, exp_res.base_address));
				if (status !== exp_res.status)
					report_mismatch($sformatf("status %0d, predicted %0d",
						status, exp_res.status));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int pick;
		int idx;
		page_run_t run;
		logic [1:0] range_mode;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		send_request(MODE_ALLOC, 0, 32'h0, 8'h00);
		send_request(MODE_ALLOC, 1, 32'hffff_ffff, 8'hff);
		send_request(MODE_ALLOC, PAGE_BYTES, 32'h0, 8'h11);
		send_request(MODE_ALLOC, PAGE_BYTES + 1, 32'h0, 8'h22);
		send_request(MODE_ALLOC, MAX_SIZE, 32'h0, 8'h01);
		send_request(MODE_UNUSED, MAX_SIZE, 32'hffff_ffff, 8'hff);
		send_request(MODE_FREE, PAGE_BYTES, 32'h0000_1fff, 8'h00);
		send_request(MODE_ALLOC, 2 * PAGE_BYTES, 32'h0, 8'h33);
		send_request(MODE_ALLOC, 1, 32'h0, 8'h44);
		send_request(MODE_RETAG, 0, 32'h0000_2abc, 8'ha5);
		send_request(MODE_FREE, PAGE_BYTES, 32'h0064_0123, 8'h00);
		// ranges running off the end of the page store
		send_request(MODE_RETAG, 5 * PAGE_BYTES, ADDR_W'(NUM_PAGES - 2) << PAGE_SHIFT, 8'h5a);
		send_request(MODE_FREE, MAX_SIZE, 32'hffff_f000, 8'h00);
		send_request(MODE_FREE, MAX_SIZE, 32'h0, 8'h00);
		send_request(MODE_ALLOC, MAX_SIZE, 32'h0, 8'h77);
		send_request(MODE_ALLOC, 0, 32'h0, 8'h78);
		send_request(MODE_FREE, 1, (ADDR_W'(NUM_PAGES - 1) << PAGE_SHIFT) | 32'hfff, 8'h00);
		send_request(MODE_ALLOC, 1, 32'h0, 8'h79);
		send_request(MODE_FREE, MAX_SIZE, 32'h0, 8'h00);
		send_request(MODE_UNUSED, 0, 32'h0, 8'h00);

		wait_for_drain();
		live_runs.delete();
		repeat ($urandom_range(20, 60)) @(posedge clk);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2) begin
				wait_for_drain();
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_request(MODE_ALLOC, $urandom_range(0, 16 * PAGE_BYTES), $urandom,
					$urandom_range(0, 255));
			end else if (pick < 46) begin
				send_request(MODE_ALLOC, $urandom_range(256, NUM_PAGES) * PAGE_BYTES
					- $urandom_range(0, PAGE_BYTES - 1), $urandom, $urandom_range(0, 255));
			end else if (pick < 80 && live_runs.size() > 0) begin
				idx = $urandom_range(0, live_runs.size() - 1);
				run = live_runs[idx];
				range_mode = (pick < 68) ? MODE_FREE : MODE_RETAG;
				if (range_mode == MODE_FREE)
					live_runs.delete(idx);
				send_request(range_mode, run.pages * PAGE_BYTES - $urandom_range(0, PAGE_BYTES - 1),
					(ADDR_W'(run.first_page) << PAGE_SHIFT) | $urandom_range(0, PAGE_BYTES - 1),
					$urandom_range(0, 255));
			end else if (pick < 84) begin
				live_runs.delete();
				send_request(MODE_FREE, MAX_SIZE, $urandom_range(0, PAGE_BYTES - 1),
					$urandom_range(0, 255));
			end else begin
				send_request(2'($urandom), $urandom_range(0, MAX_SIZE), $urandom,
					$urandom_range(0, 255));
			end
		end

		wait_for_drain();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
